>>> sv/sorted_array_min_priority_queue_core_defines.svh
// Assertion macros used by the priority queue datapath
`ifndef SORTED_ARRAY_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_ARRAY_MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SAPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sapq_pkg.sv
// Types and constants of the sorted-array priority queue
`default_nettype none

package sapq_pkg;

	localparam int OPCODE_W = 2;
	localparam int VALUE_FIELD_W = 32;
	localparam int MIN_FIELD_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_FIELD_W = 4;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_PEEK   = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_HOLD
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic    accept;
		logic    ins;
		logic    del;
		logic    take;
		status_t status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> sv/sapq_req_if.sv
// Request channel: opcode and value with valid/ready
`default_nettype none

interface sapq_req_if
	import sapq_pkg::*;
;
	logic                            valid;
	logic                            ready;
	logic [OPCODE_W-1:0]             opcode;
	logic signed [VALUE_FIELD_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

>>> sv/sapq_rsp_if.sv
// Response channel: minimum, status and count with valid/ready
`default_nettype none

interface sapq_rsp_if
	import sapq_pkg::*;
;
	logic                          valid;
	logic                          ready;
	logic signed [MIN_FIELD_W-1:0] head_value;
	logic [STATUS_W-1:0]           status;
	logic [COUNT_FIELD_W-1:0]      count;

	modport source (output valid, output head_value, output status, output count, input ready);
	modport sink (input valid, input head_value, input status, input count, output ready);
endinterface

`default_nettype wire

>>> sv/sorted_array_min_priority_queue_core.sv
// Top level of the sorted-array min-priority queue
//
//  channel | modport | payload                    | transaction
//  --------+---------+----------------------------+------------------------
//  req     | sink    | opcode, value              | one operation
//  rsp     | source  | head_value, status, count  | one result per request
//
// One transaction per cycle: all cells compare and shift in parallel in the
// accept cycle, and the result shows on rsp the following cycle.
// The result register frees in the same cycle it is taken, so req stays ready
// while rsp.ready is high; req stalls only while a result waits unclaimed.
// Reset empties the queue at once; stored values need no clearing.
`default_nettype none

module sorted_array_min_priority_queue_core
	import sapq_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int VALUE_WIDTH = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sapq_req_if.sink  req,
	sapq_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sapq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.opcode    (req.opcode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sapq_dp #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (req.value),
		.cmd        (cmd),
		.stat       (stat),
		.head_value (rsp.head_value),
		.status     (rsp.status),
		.count      (rsp.count)
	);

endmodule

`default_nettype wire

>>> sv/sapq_ctrl.sv
// Controller: handshake state machine and operation decode
`default_nettype none

module sapq_ctrl
	import sapq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [OPCODE_W-1:0] opcode,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire dp_stat_t            stat,
	output dp_cmd_t                  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		in_ready   = (state_q == CS_IDLE) || out_ready;
		out_valid  = (state_q == CS_HOLD);
		accept     = in_valid && in_ready;
		cmd        = '0;
		cmd.accept = accept;
		cmd.status = STATUS_OK;

		unique case (state_q)
			CS_IDLE: state_nxt = accept ? CS_HOLD : CS_IDLE;
			CS_HOLD: begin
				if (accept) begin
					state_nxt = CS_HOLD;
				end else if (out_ready) begin
					state_nxt = CS_IDLE;
				end else begin
					state_nxt = CS_HOLD;
				end
			end
			default: state_nxt = CS_IDLE;
		endcase

		// unknown opcodes fall through as a no-op with status ok
		unique case (opcode)
			OP_INSERT: begin
				cmd.ins    = accept && !stat.full;
				cmd.status = stat.full ? STATUS_FULL : STATUS_OK;
			end
			OP_DELETE: begin
				cmd.del    = accept && !stat.empty;
				cmd.take   = !stat.empty;
				cmd.status = stat.empty ? STATUS_EMPTY : STATUS_OK;
			end
			OP_PEEK: begin
				cmd.take   = !stat.empty;
				cmd.status = stat.empty ? STATUS_EMPTY : STATUS_OK;
			end
			default: cmd.status = STATUS_OK;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/sapq_dp.sv
// Datapath: sorted shift-register cells, fill count and result register
`default_nettype none

`include "sorted_array_min_priority_queue_core_defines.svh"

module sapq_dp
	import sapq_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic signed [VALUE_FIELD_W-1:0] value,
	input  wire dp_cmd_t                         cmd,
	output dp_stat_t                             stat,
	output logic signed [MIN_FIELD_W-1:0]        head_value,
	output logic [STATUS_W-1:0]                  status,
	output logic [COUNT_FIELD_W-1:0]             count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [VALUE_WIDTH-1:0] ent_q [DEPTH];
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 cnt_nxt;
	logic signed [VALUE_WIDTH-1:0] in_val;
	logic [DEPTH-1:0]              gt;
	logic signed [MIN_FIELD_W-1:0] min_q;
	status_t                       status_q;
	logic [COUNT_FIELD_W-1:0]      count_q;

	assign in_val     = VALUE_WIDTH'(value);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_comb begin
		if (cmd.ins) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (cmd.del) begin
			cnt_nxt = cnt_q - CW'(1);
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	// each cell compares against the new value and picks its neighbor on a shift
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] ins_val;
		logic signed [VALUE_WIDTH-1:0] del_val;

		assign gt[g] = (CW'(g) < cnt_q) && (ent_q[g] > in_val);

		if (g == 0) begin : g_head
			assign ins_val = (gt[g] || cnt_q == CW'(g)) ? in_val : ent_q[g];
		end else begin : g_body
			assign ins_val = gt[g-1] ? ent_q[g-1] :
				(gt[g] || cnt_q == CW'(g)) ? in_val : ent_q[g];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign del_val = ent_q[g];
		end else begin : g_mid
			assign del_val = ent_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				ent_q[g] <= ins_val;
			end else if (cmd.del) begin
				ent_q[g] <= del_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			min_q    <= cmd.take ? MIN_FIELD_W'(ent_q[0]) : '0;
			status_q <= cmd.status;
			count_q  <= COUNT_FIELD_W'(cnt_nxt);
		end
	end

	assign head_value = min_q;
	assign status     = status_q;
	assign count      = count_q;

	`SAPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "fill count above depth")
	`SAPQ_ASSERT_NEXT(a_ins_cnt, cmd.ins, cnt_q == $past(cnt_q) + CW'(1), "insert lost count")
	`SAPQ_ASSERT_NEXT(a_del_cnt, cmd.del, cnt_q == $past(cnt_q) - CW'(1), "delete lost count")
	`SAPQ_ASSERT_NOW(a_head_sorted, cnt_q >= CW'(2), ent_q[0] <= ent_q[1], "head out of order")

endmodule

`default_nettype wire
